// ===== design/oske_pkg.sv =====
// Package with shared types, codes and helpers of the scalar key encoder.
`default_nettype none
package oske_pkg;

	// Scalar kinds as they arrive on the input channel.
	typedef enum logic [2:0] {
		KIND_NIL       = 3'd0,
		KIND_UNDEF     = 3'd1,
		KIND_BOOL      = 3'd2,
		KIND_SINT      = 3'd3,
		KIND_UINT      = 3'd4,
		KIND_F32       = 3'd5,
		KIND_F64       = 3'd6,
		KIND_TIMESTAMP = 3'd7
	} kind_t;

	// Type codes that open each encoded key.
	localparam logic [7:0] CODE_NIL       = 8'h01;
	localparam logic [7:0] CODE_UNDEF     = 8'h02;
	localparam logic [7:0] CODE_FALSE     = 8'h05;
	localparam logic [7:0] CODE_TRUE      = 8'h06;
	localparam logic [7:0] CODE_INT_ZERO  = 8'h20;
	localparam logic [7:0] CODE_F32       = 8'h34;
	localparam logic [7:0] CODE_F64       = 8'h35;
	localparam logic [7:0] CODE_TIMESTAMP = 8'h40;

	// Canonical patterns and sign masks for the float transforms.
	localparam logic [31:0] F32_QNAN     = 32'h7fc0_0000;
	localparam logic [31:0] F32_SIGN     = 32'h8000_0000;
	localparam logic [31:0] F32_EXP      = 32'h7f80_0000;
	localparam logic [63:0] F64_QNAN     = 64'h7ff8_0000_0000_0000;
	localparam logic [63:0] F64_SIGN     = 64'h8000_0000_0000_0000;
	localparam logic [63:0] F64_EXP      = 64'h7ff0_0000_0000_0000;

	// Default depth of the queue between classifier and serializer.
	localparam int QUEUE_DEPTH_DEF = 2;

	// One classified item: type code, payload (low nbytes bytes are sent,
	// most significant first) and the payload length.
	typedef struct packed {
		logic [7:0]  code;
		logic [63:0] payload;
		logic [3:0]  nbytes;
	} entry_t;

	// Number of significant bytes in a 64-bit value, 0 for zero.
	function automatic logic [3:0] sig_bytes(input logic [63:0] x);
		logic [3:0] n;
		n = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (x[8*i +: 8] != 8'h00) begin
				n = 4'(i + 1);
			end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== design/oske_if.sv =====
// Handshake interfaces for the input scalar and the output key bytes.
`default_nettype none
interface oske_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [63:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface oske_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== design/oske_front.sv =====
// Front stage: accepts a scalar word and classifies it into code and payload.
`default_nettype none
module oske_front (
	input  wire                 clk,
	input  wire                 arst_n,
	oske_in_if.sink             item,
	output oske_pkg::entry_t    ent,
	output logic                ent_valid,
	input  wire                 ent_ready
);
	import oske_pkg::*;

	entry_t      ent_d;
	entry_t      ent_s1;
	logic        valid_s1;
	logic [63:0] v;
	logic [31:0] b32;
	logic [63:0] b64;
	logic [3:0]  n;

	assign v = item.value;

	// Classify the incoming word into its type code and payload.
	always_comb begin
		ent_d = '{code: CODE_NIL, payload: 64'd0, nbytes: 4'd0};
		b32   = v[31:0];
		b64   = v;
		n     = sig_bytes(v);
		unique case (kind_t'(item.kind))
			KIND_NIL: begin
				ent_d.code = CODE_NIL;
			end
			KIND_UNDEF: begin
				ent_d.code = CODE_UNDEF;
			end
			KIND_BOOL: begin
				ent_d.code = v[0] ? CODE_TRUE : CODE_FALSE;
			end
			KIND_SINT: begin
				if (v[63]) begin
					// The magnitude minus one is the complement; the
					// payload is the low n bytes of the raw value.
					n = sig_bytes(~v);
					if (n == 4'd0) begin
						n = 4'd1;
					end
					ent_d.code    = CODE_INT_ZERO - {4'd0, n};
					ent_d.payload = v;
					ent_d.nbytes  = n;
				end else begin
					ent_d.code    = CODE_INT_ZERO + {4'd0, n};
					ent_d.payload = v;
					ent_d.nbytes  = n;
				end
			end
			KIND_UINT: begin
				ent_d.code    = CODE_INT_ZERO + {4'd0, n};
				ent_d.payload = v;
				ent_d.nbytes  = n;
			end
			KIND_F32: begin
				if ((b32 & F32_EXP) == F32_EXP && (b32 & ~(F32_EXP | F32_SIGN)) != 32'd0) begin
					b32 = F32_QNAN;
				end else if (b32 == F32_SIGN) begin
					b32 = 32'd0;
				end
				b32 = b32[31] ? ~b32 : (b32 ^ F32_SIGN);
				ent_d.code    = CODE_F32;
				ent_d.payload = {32'd0, b32};
				ent_d.nbytes  = 4'd4;
			end
			KIND_F64: begin
				if ((b64 & F64_EXP) == F64_EXP && (b64 & ~(F64_EXP | F64_SIGN)) != 64'd0) begin
					b64 = F64_QNAN;
				end else if (b64 == F64_SIGN) begin
					b64 = 64'd0;
				end
				b64 = b64[63] ? ~b64 : (b64 ^ F64_SIGN);
				ent_d.code    = CODE_F64;
				ent_d.payload = b64;
				ent_d.nbytes  = 4'd8;
			end
			KIND_TIMESTAMP: begin
				ent_d.code    = CODE_TIMESTAMP;
				ent_d.payload = v ^ F64_SIGN;
				ent_d.nbytes  = 4'd8;
			end
			default: begin
				ent_d.code = CODE_NIL;
			end
		endcase
	end

	// Pipeline register between the input and the queue.
	assign item.ready = !valid_s1 || ent_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (ent_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ent_s1 <= ent_d;
		end
	end

	assign ent       = ent_s1;
	assign ent_valid = valid_s1;

endmodule
`default_nettype wire

// ===== design/oske_queue.sv =====
// Small queue of classified entries between the front and back stages.
`default_nettype none
module oske_queue #(
	parameter int DEPTH = oske_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  oske_pkg::entry_t    wr_ent,
	input  wire                 wr_valid,
	output logic                wr_ready,
	output oske_pkg::entry_t    rd_ent,
	output logic                rd_valid,
	input  wire                 rd_ready
);
	import oske_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign wr_ready = (count_q != FULL_CNT);
	assign rd_valid = (count_q != '0);
	assign rd_ent   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	// Pointer and fill count update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

endmodule
`default_nettype wire

// ===== design/oske_back.sv =====
// Back stage: serializes one entry into key bytes, code byte first.
`default_nettype none
module oske_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  oske_pkg::entry_t    ent,
	input  wire                 ent_valid,
	output logic                ent_ready,
	oske_out_if.source          key
);
	import oske_pkg::*;

	logic        busy_q;
	logic        code_phase_q;
	logic [3:0]  rem_q;
	logic [7:0]  code_q;
	logic [63:0] payload_q;
	logic [2:0]  byte_sel;
	logic        fire;

	// Byte selection: code first, then payload bytes from the top down.
	assign byte_sel     = rem_q[2:0] - 3'd1;
	assign key.valid    = busy_q;
	assign key.out_byte = code_phase_q ? code_q : payload_q[8*byte_sel +: 8];
	assign key.last     = code_phase_q ? (rem_q == 4'd0) : (rem_q == 4'd1);
	assign fire         = key.valid && key.ready;
	assign ent_ready    = !busy_q || (fire && key.last);

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			code_phase_q <= 1'b0;
			rem_q        <= 4'd0;
		end else if (ent_valid && ent_ready) begin
			busy_q       <= 1'b1;
			code_phase_q <= 1'b1;
			rem_q        <= ent.nbytes;
		end else if (fire) begin
			if (key.last) begin
				busy_q <= 1'b0;
			end else if (code_phase_q) begin
				code_phase_q <= 1'b0;
			end else begin
				rem_q <= rem_q - 4'd1;
			end
		end
	end

	// Held entry payload.
	always_ff @(posedge clk) begin
		if (ent_valid && ent_ready) begin
			code_q    <= ent.code;
			payload_q <= ent.payload;
		end
	end

endmodule
`default_nettype wire

// ===== design/order_preserving_scalar_encoder.sv =====
// Top level of the order-preserving scalar key encoder.
//
// Usage: the item channel takes one word per scalar, a 3-bit kind and a
// 64-bit raw operand (two's complement integer, IEEE bit pattern, or a
// bool in bit 0). The key channel returns the byte-comparable encoding of
// that scalar, one byte per word, type code first, with last set on the
// final byte. An item yields 1 to 9 bytes.
// Path: an accepted item passes the front pipeline register and the entry
// queue, and its entry is then taken into the byte serializer, which
// offers the code byte first.
// Serializer: an item occupies the byte serializer for its code byte and
// then its n payload bytes, where n is its payload length (0 to 8);
// the byte-wide key channel bounds the item rate. The classifier and the
// entry queue keep taking items while bytes are being sent.
// Reset: arst_n clears all control state at once; the block holds no
// items afterward and the item channel shows ready.
// Stalls: when the receiver holds ready low, the current byte is held,
// the queue and the front pipeline register fill, and then the item
// channel drops ready. No byte is lost or repeated.
`default_nettype none
module order_preserving_scalar_encoder #(
	parameter int QUEUE_DEPTH = oske_pkg::QUEUE_DEPTH_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	oske_in_if.sink     item,
	oske_out_if.source  key
);
	import oske_pkg::*;

	entry_t front_ent;
	logic   front_valid;
	logic   front_ready;
	entry_t back_ent;
	logic   back_valid;
	logic   back_ready;

	oske_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.ent       (front_ent),
		.ent_valid (front_valid),
		.ent_ready (front_ready)
	);

	oske_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_ent   (front_ent),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_ent   (back_ent),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	oske_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent       (back_ent),
		.ent_valid (back_valid),
		.ent_ready (back_ready),
		.key       (key)
	);

endmodule
`default_nettype wire
